@@ sv/btcr_pkg.sv @@
`default_nettype none

package btcr_pkg;

    localparam int FONT_GLYPHS  = 256;
    localparam int MAX_COLUMNS  = 256;
    localparam int MAX_ROWS     = 256;

    localparam int FONT_AW      = $clog2(FONT_GLYPHS);
    localparam int GLYPH_SIZE   = 8;
    localparam int GLYPH_BITS   = GLYPH_SIZE * GLYPH_SIZE;
    localparam int PIX_CNT_W    = $clog2(GLYPH_BITS);
    localparam int OFS_W        = $clog2(GLYPH_SIZE);

    localparam int CODE_W       = 8;
    localparam int CURSOR_W     = 8;
    localparam int DIM_W        = 9;
    localparam int COORD_W      = 11;
    localparam int CHAN_W       = 8;
    localparam int COLOR_W      = 3 * CHAN_W;
    localparam int OP_W         = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = COLOR_W;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_CURSOR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR     = 2'd3;

    localparam logic [DIM_W-1:0]   TEXT_COLUMNS_RST = 9'd128;
    localparam logic [DIM_W-1:0]   TEXT_ROWS_RST    = 9'd96;
    localparam logic [COLOR_W-1:0] FG_COLOR_RST     = 24'hA0A0A0;
    localparam logic [COLOR_W-1:0] BG_COLOR_RST     = 24'h000000;

    localparam logic [CODE_W-1:0]  NEWLINE_CODE     = 8'd10;

    // one character job handed from front to back
    typedef struct packed {
        logic                  newline;
        logic                  scroll;
        logic [COORD_W-1:0]    base_x;
        logic [COORD_W-1:0]    base_y;
        logic [GLYPH_BITS-1:0] glyph;
    } job_t;

endpackage

`default_nettype wire

@@ sv/btcr_cmd_if.sv @@
`default_nettype none

interface btcr_cmd_if import btcr_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [CODE_W-1:0]     char_code;
    logic [GLYPH_BITS-1:0] glyph_bits;
    logic [CURSOR_W-1:0]   new_row;
    logic [CURSOR_W-1:0]   new_column;

    modport source (
        output valid, operation, char_code, glyph_bits, new_row, new_column,
        input  ready
    );
    modport sink (
        input  valid, operation, char_code, glyph_bits, new_row, new_column,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/btcr_pix_if.sv @@
`default_nettype none

interface btcr_pix_if import btcr_pkg::*;;
    logic               valid;
    logic               ready;
    logic               pixel_valid;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               scroll_request;
    logic               last_of_run;

    modport source (
        output valid, pixel_valid, pixel_x, pixel_y, red, green, blue,
               scroll_request, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, pixel_valid, pixel_x, pixel_y, red, green, blue,
               scroll_request, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/btcr_front.sv @@
`default_nettype none

module btcr_front import btcr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    btcr_cmd_if.sink                command,
    input  wire logic [DIM_W-1:0]   text_columns,
    input  wire logic [DIM_W-1:0]   text_rows,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output job_t                    push_job
);

    logic [GLYPH_BITS-1:0] font_mem [FONT_GLYPHS];
    logic [GLYPH_BITS-1:0] glyph_rd_reg;

    logic [CURSOR_W-1:0]   col_reg, col_next;
    logic [CURSOR_W-1:0]   row_reg, row_next;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_newline_reg;
    logic                  s1_scroll_reg;
    logic                  s1_glyph_ok_reg;
    logic [COORD_W-1:0]    s1_base_x_reg;
    logic [COORD_W-1:0]    s1_base_y_reg;

    logic                  accept;
    logic                  is_put, is_load, is_cursor;
    logic                  is_newline;
    logic                  glyph_ok;
    logic [DIM_W-1:0]      cols_eff, rows_eff;
    logic [DIM_W-1:0]      col_inc, row_inc;
    logic                  wrap_line;
    logic                  scroll;

    assign command.ready = !s1_valid_reg || push_ready;
    assign accept        = command.valid && command.ready;
    assign is_put        = command.operation == OP_PUT;
    assign is_load       = command.operation == OP_LOAD;
    assign is_cursor     = command.operation == OP_CURSOR;
    assign is_newline    = command.char_code == NEWLINE_CODE;
    assign glyph_ok      = {1'b0, command.char_code} < (CODE_W + 1)'(FONT_GLYPHS);

    // screen size clamped to the supported range
    always_comb
    begin
        if (text_columns == '0)
            cols_eff = DIM_W'(1);
        else if (text_columns > DIM_W'(MAX_COLUMNS))
            cols_eff = DIM_W'(MAX_COLUMNS);
        else
            cols_eff = text_columns;

        if (text_rows == '0)
            rows_eff = DIM_W'(1);
        else if (text_rows > DIM_W'(MAX_ROWS))
            rows_eff = DIM_W'(MAX_ROWS);
        else
            rows_eff = text_rows;
    end

    assign col_inc = {1'b0, col_reg} + DIM_W'(1);
    assign row_inc = {1'b0, row_reg} + DIM_W'(1);

    // cursor advance for a put, or a move for a cursor item
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        scroll    = 1'b0;
        wrap_line = is_newline || (col_inc >= cols_eff);

        if (accept && is_cursor)
        begin
            row_next = command.new_row;
            col_next = command.new_column;
        end
        else if (accept && is_put)
        begin
            if (wrap_line)
            begin
                col_next = '0;
                if (row_inc >= rows_eff)
                begin
                    row_next = CURSOR_W'(rows_eff - DIM_W'(1));
                    scroll   = 1'b1;
                end
                else
                begin
                    row_next = row_inc[CURSOR_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[CURSOR_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (accept && is_put)
            s1_valid_next = 1'b1;
        else if (push_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_put)
        begin
            s1_newline_reg  <= is_newline;
            s1_scroll_reg   <= scroll;
            s1_glyph_ok_reg <= glyph_ok;
            s1_base_x_reg   <= {col_reg, OFS_W'(0)};
            s1_base_y_reg   <= {row_reg, OFS_W'(0)};
        end
    end

    // font store: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && is_load && glyph_ok)
            font_mem[command.char_code[FONT_AW-1:0]] <= command.glyph_bits;
        if (accept && is_put)
            glyph_rd_reg <= font_mem[command.char_code[FONT_AW-1:0]];
    end

    assign push_valid       = s1_valid_reg;
    assign push_job.newline = s1_newline_reg;
    assign push_job.scroll  = s1_scroll_reg;
    assign push_job.base_x  = s1_base_x_reg;
    assign push_job.base_y  = s1_base_y_reg;
    assign push_job.glyph   = s1_glyph_ok_reg ? glyph_rd_reg : '0;

    a_put_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_put |=> s1_valid_reg)
        else $error("put item did not reach the glyph stage");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !push_ready |=> s1_valid_reg && $stable(s1_base_x_reg))
        else $error("stalled glyph stage lost its job");

endmodule

`default_nettype wire

@@ sv/btcr_queue.sv @@
`default_nettype none

module btcr_queue import btcr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  job_t      push_job,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output job_t      pop_job
);

    job_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign push_ready = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QUEUE_AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QUEUE_AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ sv/btcr_back.sv @@
`default_nettype none

module btcr_back import btcr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               job_valid,
    output logic                    job_ready,
    input  job_t                    job,
    input  wire logic [COLOR_W-1:0] foreground_color,
    input  wire logic [COLOR_W-1:0] background_color,
    btcr_pix_if.source              pixel
);

    logic                  active_reg, active_next;
    logic [PIX_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [GLYPH_BITS-1:0] glyph_reg, glyph_next;
    logic                  newline_reg;
    logic                  scroll_reg;
    logic [COORD_W-1:0]    base_x_reg;
    logic [COORD_W-1:0]    base_y_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_pix_reg;
    logic [COORD_W-1:0]    out_x_reg;
    logic [COORD_W-1:0]    out_y_reg;
    logic [COLOR_W-1:0]    out_color_reg;
    logic                  out_scroll_reg;
    logic                  out_last_reg;

    logic                  emit;
    logic                  last;
    logic [COLOR_W-1:0]    color;

    assign emit      = active_reg && (!out_valid_reg || pixel.ready);
    assign last      = newline_reg || (cnt_reg == PIX_CNT_W'(GLYPH_BITS - 1));
    assign job_ready = !active_reg || (emit && last);
    assign color     = glyph_reg[GLYPH_BITS-1] ? foreground_color : background_color;

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        glyph_next  = glyph_reg;
        if (job_valid && job_ready)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            glyph_next  = job.glyph;
        end
        else if (emit && last)
        begin
            active_next = 1'b0;
        end
        else if (emit)
        begin
            cnt_next   = cnt_reg + PIX_CNT_W'(1);
            glyph_next = {glyph_reg[GLYPH_BITS-2:0], 1'b0};
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (pixel.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        glyph_reg <= glyph_next;
        if (job_valid && job_ready)
        begin
            newline_reg <= job.newline;
            scroll_reg  <= job.scroll;
            base_x_reg  <= job.base_x;
            base_y_reg  <= job.base_y;
        end
        if (emit)
        begin
            out_last_reg   <= last;
            out_scroll_reg <= last && scroll_reg;
            if (newline_reg)
            begin
                out_pix_reg   <= 1'b0;
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_color_reg <= '0;
            end
            else
            begin
                out_pix_reg   <= 1'b1;
                out_x_reg     <= base_x_reg + COORD_W'(cnt_reg[OFS_W-1:0]);
                out_y_reg     <= base_y_reg + COORD_W'(cnt_reg[PIX_CNT_W-1:OFS_W]);
                out_color_reg <= color;
            end
        end
    end

    assign pixel.valid          = out_valid_reg;
    assign pixel.pixel_valid    = out_pix_reg;
    assign pixel.pixel_x        = out_x_reg;
    assign pixel.pixel_y        = out_y_reg;
    assign pixel.red            = out_color_reg[COLOR_W-1 -: CHAN_W];
    assign pixel.green          = out_color_reg[CHAN_W +: CHAN_W];
    assign pixel.blue           = out_color_reg[CHAN_W-1:0];
    assign pixel.scroll_request = out_scroll_reg;
    assign pixel.last_of_run    = out_last_reg;

    a_scroll_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.scroll_request |-> pixel.last_of_run)
        else $error("scroll request away from the last item of a run");

    a_newline_single: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && !pixel.pixel_valid |-> pixel.last_of_run && pixel.pixel_x == '0)
        else $error("newline result malformed");

endmodule

`default_nettype wire

@@ sv/bitmap_text_console_renderer.sv @@
`default_nettype none

// Text console renderer with an 8x8 bitmap font. Items on the command channel
// either load a 64-bit glyph into the 256-entry font store, move the cursor, or
// put a character. A printable character produces 64 pixel items on the pixel
// channel, row-major from glyph bit 63, in foreground or background colour; a
// newline (code 10) produces one item with pixel_valid low. The last item of a
// character carries last_of_run, and scroll_request when the cursor left the
// last text row; the framebuffer side performs the scroll itself. A glyph must
// be loaded before it is drawn. Rate: the back-end pixel sequencer issues one
// item per cycle while the pixel channel is not stalled, and takes a new job
// from the queue in the same cycle as it issues the last item of the previous
// one. Load, cursor and newline items are accepted one per cycle while the
// 4-entry job queue and the glyph read stage have room. There is no clearing
// pass after reset. Registers are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while the block is idle; it is not enforced.
module bitmap_text_console_renderer import btcr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    btcr_cmd_if.sink                   command,
    btcr_pix_if.source                 pixel,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [DIM_W-1:0]   text_columns_reg, text_columns_next;
    logic [DIM_W-1:0]   text_rows_reg, text_rows_next;
    logic [COLOR_W-1:0] ink_color_reg, ink_color_next;
    logic [COLOR_W-1:0] paper_color_reg, paper_color_next;

    // front to queue, queue to back
    logic push_valid, push_ready;
    job_t push_job;
    logic pop_valid, pop_ready;
    job_t pop_job;

    always_comb
    begin
        text_columns_next = text_columns_reg;
        text_rows_next    = text_rows_reg;
        ink_color_next    = ink_color_reg;
        paper_color_next  = paper_color_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_TEXT_COLUMNS: text_columns_next = cfg_data[DIM_W-1:0];
                CFG_TEXT_ROWS:    text_rows_next    = cfg_data[DIM_W-1:0];
                CFG_FG_COLOR:     ink_color_next    = cfg_data[COLOR_W-1:0];
                CFG_BG_COLOR:     paper_color_next  = cfg_data[COLOR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_columns_reg <= TEXT_COLUMNS_RST;
            text_rows_reg    <= TEXT_ROWS_RST;
            ink_color_reg    <= FG_COLOR_RST;
            paper_color_reg  <= BG_COLOR_RST;
        end
        else
        begin
            text_columns_reg <= text_columns_next;
            text_rows_reg    <= text_rows_next;
            ink_color_reg    <= ink_color_next;
            paper_color_reg  <= paper_color_next;
        end
    end

    // front: cursor tracking, font store, glyph fetch
    btcr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .text_columns (text_columns_reg),
        .text_rows    (text_rows_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_job     (push_job)
    );

    // short job queue decouples command intake from pixel output
    btcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // back: pixel sequencer with output register
    btcr_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .job_valid        (pop_valid),
        .job_ready        (pop_ready),
        .job              (pop_job),
        .foreground_color (ink_color_reg),
        .background_color (paper_color_reg),
        .pixel            (pixel)
    );

endmodule

`default_nettype wire

@@ tb/console_pixel_checker.sv @@
module console_pixel_checker import btcr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    btcr_cmd_if                        command,
    btcr_pix_if                        pixel,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         mismatch_count,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               pixel_valid;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               scroll_request;
        logic               last_of_run;
    } pixel_item_t;

    pixel_item_t           expected_pixels[$];
    pixel_item_t           got_pixel;
    pixel_item_t           want_pixel;

    logic [DIM_W-1:0]      columns_reg;
    logic [DIM_W-1:0]      rows_reg;
    logic [COLOR_W-1:0]    ink_color;
    logic [COLOR_W-1:0]    paper_color;
    logic [CURSOR_W-1:0]   cur_row;
    logic [CURSOR_W-1:0]   cur_col;
    logic [GLYPH_BITS-1:0] font[FONT_GLYPHS];

    function automatic int clamp_dim(logic [DIM_W-1:0] v, int maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic string describe(pixel_item_t p);
        return $sformatf("pv=%0d x=%0d y=%0d rgb=%02h%02h%02h scroll=%0d last=%0d",
                         p.pixel_valid, p.pixel_x, p.pixel_y, p.red, p.green, p.blue,
                         p.scroll_request, p.last_of_run);
    endfunction

    // cursor to column 0 of the next row, pinned to the last row on scroll
    task automatic line_feed(output logic scroll);
        int rows;
        int next_row;
        rows = clamp_dim(rows_reg, MAX_ROWS);
        next_row = int'(cur_row) + 1;
        cur_col = '0;
        if (next_row >= rows) begin
            cur_row = CURSOR_W'(rows - 1);
            scroll = 1'b1;
        end
        else begin
            cur_row = CURSOR_W'(next_row);
            scroll = 1'b0;
        end
    endtask

    task automatic render_glyph(logic [CODE_W-1:0] code);
        logic [GLYPH_BITS-1:0] bits;
        logic [COORD_W-1:0]    base_x;
        logic [COORD_W-1:0]    base_y;
        logic [COLOR_W-1:0]    color;
        logic                  scroll;
        pixel_item_t           pix;
        bits = (int'(code) < FONT_GLYPHS) ? font[code] : '0;
        base_x = COORD_W'(int'(cur_col) * GLYPH_SIZE);
        base_y = COORD_W'(int'(cur_row) * GLYPH_SIZE);
        // advance first, the flags only go on the last pixel
        if (int'(cur_col) + 1 >= clamp_dim(columns_reg, MAX_COLUMNS))
            line_feed(scroll);
        else begin
            cur_col = cur_col + 1'b1;
            scroll = 1'b0;
        end
        for (int k = 0; k < GLYPH_BITS; k++) begin
            color = bits[GLYPH_BITS-1-k] ? ink_color : paper_color;
            pix.pixel_valid = 1'b1;
            pix.pixel_x = base_x + COORD_W'(k % GLYPH_SIZE);
            pix.pixel_y = base_y + COORD_W'(k / GLYPH_SIZE);
            pix.red = color[23:16];
            pix.green = color[15:8];
            pix.blue = color[7:0];
            pix.scroll_request = (k == GLYPH_BITS - 1) ? scroll : 1'b0;
            pix.last_of_run = (k == GLYPH_BITS - 1);
            expected_pixels.push_back(pix);
        end
    endtask

    task automatic predict_command(logic [OP_W-1:0] op, logic [CODE_W-1:0] code,
                                   logic [GLYPH_BITS-1:0] glyph,
                                   logic [CURSOR_W-1:0] row, logic [CURSOR_W-1:0] col);
        pixel_item_t pix;
        case (op)
            OP_LOAD:
                if (int'(code) < FONT_GLYPHS)
                    font[code] = glyph;
            OP_CURSOR:
            begin
                cur_row = row;
                cur_col = col;
            end
            OP_PUT:
                if (code == NEWLINE_CODE) begin
                    pix = '0;
                    line_feed(pix.scroll_request);
                    pix.last_of_run = 1'b1;
                    expected_pixels.push_back(pix);
                end
                else
                    render_glyph(code);
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            columns_reg = TEXT_COLUMNS_RST;
            rows_reg = TEXT_ROWS_RST;
            ink_color = FG_COLOR_RST;
            paper_color = BG_COLOR_RST;
            cur_row = '0;
            cur_col = '0;
            expected_pixels.delete();
            mismatch_count = 0;
            outstanding = 0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_TEXT_COLUMNS: columns_reg = cfg_data[DIM_W-1:0];
                    CFG_TEXT_ROWS:    rows_reg = cfg_data[DIM_W-1:0];
                    CFG_FG_COLOR:     ink_color = cfg_data[COLOR_W-1:0];
                    CFG_BG_COLOR:     paper_color = cfg_data[COLOR_W-1:0];
                    default:          ;
                endcase
            end
            if (pixel.valid && pixel.ready) begin
                got_pixel.pixel_valid = pixel.pixel_valid;
                got_pixel.pixel_x = pixel.pixel_x;
                got_pixel.pixel_y = pixel.pixel_y;
                got_pixel.red = pixel.red;
                got_pixel.green = pixel.green;
                got_pixel.blue = pixel.blue;
                got_pixel.scroll_request = pixel.scroll_request;
                got_pixel.last_of_run = pixel.last_of_run;
                if (expected_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("pixel item with none expected: %s", describe(got_pixel));
                end
                else begin
                    want_pixel = expected_pixels.pop_front();
                    if (got_pixel !== want_pixel) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("pixel mismatch at %0t\n  expected %s\n  actual   %s",
                                     $realtime, describe(want_pixel), describe(got_pixel));
                    end
                end
            end
            if (command.valid && command.ready)
                predict_command(command.operation, command.char_code, command.glyph_bits,
                                command.new_row, command.new_column);
            outstanding = expected_pixels.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top import btcr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // the one operation code the block has no use for
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 440;
    localparam int NUM_PHASES    = 7;
    localparam int SETTLE_CYCLES = 20;   // job queue plus glyph read stage, with margin
    localparam int HOLD_CYCLES   = 400;  // long receiver hold-off, fills the job queue

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatch_count;
    int                    outstanding;

    // quiet: no idling on either side in the last part of the run
    bit                    quiet;
    bit                    hold_off_req;

    // glyphs written so far, a put only ever draws one of these
    bit                    glyph_loaded[FONT_GLYPHS];
    logic [CODE_W-1:0]     loaded_codes[$];

    // effective screen size, used to aim cursor moves mostly on screen
    int                    screen_cols;
    int                    screen_rows;

    btcr_cmd_if cmd_ch();
    btcr_pix_if pix_ch();

    bitmap_text_console_renderer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (cmd_ch),
        .pixel     (pix_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    console_pixel_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .command        (cmd_ch),
        .pixel          (pix_ch),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit, ten milliseconds is many times the slowest correct run
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [GLYPH_BITS-1:0] random_glyph();
        return {$urandom, $urandom};
    endfunction

    // offer one item, with an optional idle burst ahead of it; returns at the
    // falling edge after acceptance with valid still high
    task automatic send_command(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                                input logic [GLYPH_BITS-1:0] glyph,
                                input logic [CURSOR_W-1:0] row,
                                input logic [CURSOR_W-1:0] col);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.operation = op;
        cmd_ch.char_code = code;
        cmd_ch.glyph_bits = glyph;
        cmd_ch.new_row = row;
        cmd_ch.new_column = col;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        @(negedge clk);
        if (op == OP_LOAD && !glyph_loaded[code]) begin
            glyph_loaded[code] = 1'b1;
            loaded_codes.push_back(code);
        end
    endtask

    // put a character, the unused fields carry noise
    task automatic put_char(input logic [CODE_W-1:0] code);
        send_command(OP_PUT, code, random_glyph(), CURSOR_W'($urandom), CURSOR_W'($urandom));
    endtask

    task automatic load_glyph(input logic [CODE_W-1:0] code, input logic [GLYPH_BITS-1:0] g);
        send_command(OP_LOAD, code, g, CURSOR_W'($urandom), CURSOR_W'($urandom));
    endtask

    task automatic move_cursor(input int row, input int col);
        send_command(OP_CURSOR, CODE_W'($urandom), random_glyph(), CURSOR_W'(row),
                     CURSOR_W'(col));
    endtask

    // sender stops and waits for every expected pixel, then lets any
    // load or cursor items still in flight settle
    task automatic wait_idle();
        cmd_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write all four registers back to back, block must be idle
    task automatic configure(input int cols, input int rows, input int fg, input int bg);
        for (int i = 0; i < 4; i++) begin
            cfg_write = 1'b1;
            cfg_index = CFG_IDX_W'(i);
            case (CFG_IDX_W'(i))
                CFG_TEXT_COLUMNS: cfg_data = CFG_DATA_W'(cols);
                CFG_TEXT_ROWS:    cfg_data = CFG_DATA_W'(rows);
                CFG_FG_COLOR:     cfg_data = CFG_DATA_W'(fg);
                default:          cfg_data = CFG_DATA_W'(bg);
            endcase
            @(negedge clk);
        end
        cfg_write = 1'b0;
        // block clamps the dimensions to 1..256 (low 9 bits kept)
        screen_cols = (cols % 512 == 0) ? 1 : (cols % 512 > MAX_COLUMNS ? MAX_COLUMNS : cols % 512);
        screen_rows = (rows % 512 == 0) ? 1 : (rows % 512 > MAX_ROWS ? MAX_ROWS : rows % 512);
    endtask

    // one random item; returns 1 if it was an item the block ignores
    task automatic random_item(output bit ignored);
        int pick;
        pick = $urandom_range(0, 99);
        ignored = 1'b0;
        if (loaded_codes.size() == 0 || pick < 20)
            load_glyph(CODE_W'($urandom), random_glyph());
        else if (pick < 35) begin
            // half on screen, half anywhere the fields allow
            if ($urandom_range(0, 1) == 0)
                move_cursor($urandom_range(0, screen_rows - 1), $urandom_range(0, screen_cols - 1));
            else
                move_cursor($urandom_range(0, 255), $urandom_range(0, 255));
        end
        else if (pick < 40) begin
            send_command(OP_UNUSED, CODE_W'($urandom), random_glyph(), CURSOR_W'($urandom),
                         CURSOR_W'($urandom));
            ignored = 1'b1;
        end
        else if (pick < 46)
            put_char(NEWLINE_CODE);
        else
            put_char(loaded_codes[$urandom_range(0, loaded_codes.size() - 1)]);
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        pix_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                pix_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0) begin
                pix_ch.ready = 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge clk);
            end
            else
                pix_ch.ready = 1'b1;
        end
    end

    // stimulus and verdict
    initial
    begin
        int per_phase;
        int sent;
        bit ignored;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.operation = OP_PUT;
        cmd_ch.char_code = '0;
        cmd_ch.glyph_bits = '0;
        cmd_ch.new_row = '0;
        cmd_ch.new_column = '0;
        quiet = 1'b0;
        hold_off_req = 1'b0;
        screen_cols = TEXT_COLUMNS_RST;
        screen_rows = TEXT_ROWS_RST;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part at the reset register values (128 x 96)
        load_glyph(8'd0, '1);
        load_glyph(8'd255, '0);
        load_glyph(8'd65, 64'hAA55_AA55_F0F0_0F0F);
        load_glyph(NEWLINE_CODE, random_glyph());   // loading at the newline code is legal
        put_char(8'd0);
        put_char(8'd255);
        put_char(8'd65);
        put_char(NEWLINE_CODE);
        send_command(OP_UNUSED, 8'd0, random_glyph(), 8'd3, 8'd3);
        // last column of the last row: advance wraps and scrolls
        move_cursor(TEXT_ROWS_RST - 1, TEXT_COLUMNS_RST - 1);
        put_char(8'd65);
        // newline on the last row scrolls too
        put_char(NEWLINE_CODE);
        // cursor far beyond the screen: drawn as it stands, then pinned
        move_cursor(255, 255);
        put_char(8'd0);
        // second-to-last column, not last row: the second put wraps without a scroll
        move_cursor(0, TEXT_COLUMNS_RST - 2);
        put_char(8'd255);
        put_char(8'd0);
        load_glyph(8'd128, 64'h8000_0000_0000_0001);
        put_char(8'd128);
        load_glyph(8'd0, '0);
        put_char(8'd0);

        // random phases, each under its own register setting
        per_phase = RANDOM_ITEMS / NUM_PHASES;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: configure(0, 0, 24'hFFFFFF, 24'h000000);       // clamps to one cell
                1: configure(1, 1, 24'h000000, 24'hFFFFFF);
                2: configure(511, 511, 24'hFF0000, 24'h00FF00);   // clamps to 256
                3: configure(256, 256, 24'h0000FF, $urandom_range(0, 24'hFFFFFF));
                4: configure(3, 2, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
                5: configure($urandom_range(1, 8), $urandom_range(1, 8),
                             $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
                default: configure($urandom_range(0, 511), $urandom_range(0, 511),
                                   $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
            endcase
            // long receiver hold-off while the sender keeps offering items
            if (phase == 2)
                hold_off_req = 1'b1;
            // last phase runs at full rate on both sides
            if (phase == NUM_PHASES - 1)
                quiet = 1'b1;
            sent = 0;
            while (sent < per_phase) begin
                random_item(ignored);
                if (!ignored)
                    sent++;
            end
        end

        // drain, then leave time for any stray item to show up
        wait_idle();
        if (mismatch_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
